FILE: rtl/stwp_pkg.sv
// Package for the sine table waveform player.
// Holds field widths, register indexes and the pipeline control type.
// No dependencies.
package stwp_pkg;

  localparam int DEFAULT_TABLE_POINTS = 256;
  localparam int DEFAULT_SINE_BITS    = 16;

  localparam int PERIOD_W    = 24;
  localparam int MAG_W       = 16;
  localparam int OFFSET_W    = 17;
  localparam int CODE_W      = 16;
  localparam int INDEX_W     = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int SUM_W       = MAG_W + 4;

  localparam int MIDSCALE = 32768;
  localparam int CODE_MAX = 65535;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PERIOD    = 2'd0,
    REG_MAGNITUDE = 2'd1,
    REG_OFFSET    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic valid;
    logic park;
  } stage_ctl_t;

endpackage

FILE: rtl/sine_table_waveform_player_unit.sv
// Top level of the sine table waveform player.
// Instantiates stwp_sequencer, stwp_table_fill, stwp_ram and stwp_sample_path.
//
// Usage: each input transaction carries tick_present, one timer cycle. While
// period_ticks is nonzero, every period_ticks-th tick yields one output
// transaction: dac_code is midscale plus offset_code plus magnitude_code times
// the table sine, saturated to 0..65535, and sample_index is the table
// position. A period of zero parks the output: one midscale sample is sent,
// then nothing. Writing period_ticks restarts the waveform at position zero.
// The configuration channel is always ready; write it only while idle.
// Throughput is one input transaction per cycle while in_ready is high. The
// output register loads a sample after the table RAM read and the multiplier
// register; a receiver stall holds it back.
// When the receiver stalls, the pipeline fills; in_ready falls only once the
// output register and both internal stages hold samples.
// After reset the sine table is loaded into the RAM, one entry per cycle, so
// in_ready stays low until the table is full; configuration is taken meanwhile.
module sine_table_waveform_player_unit
  import stwp_pkg::*;
#(
  parameter int TABLE_POINTS = DEFAULT_TABLE_POINTS,
  parameter int SINE_BITS    = DEFAULT_SINE_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   tick_present,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [CODE_W-1:0]      dac_code,
  output logic [INDEX_W-1:0]     sample_index,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int PHASE_W = $clog2(TABLE_POINTS);

  stage_ctl_t                 issue;
  logic [PHASE_W-1:0]         issue_phase;
  logic                       issue_ready;
  logic [MAG_W-1:0]           magnitude;
  logic signed [OFFSET_W-1:0] offset;
  logic                       fill_we;
  logic [PHASE_W-1:0]         fill_waddr;
  logic [SINE_BITS-1:0]       fill_wdata;
  logic                       fill_done;
  logic                       table_re;
  logic [SINE_BITS-1:0]       table_rdata;
  logic                       in_fire;
  logic                       cfg_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = fill_done && issue_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;

  stwp_sequencer #(
    .TABLE_POINTS(TABLE_POINTS)
  ) u_sequencer (
    .clk         (clk),
    .rst         (rst),
    .in_fire     (in_fire),
    .tick_present(tick_present),
    .cfg_fire    (cfg_fire),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .issue       (issue),
    .issue_phase (issue_phase),
    .magnitude   (magnitude),
    .offset      (offset)
  );

  stwp_table_fill #(
    .TABLE_POINTS(TABLE_POINTS),
    .SINE_BITS   (SINE_BITS)
  ) u_table_fill (
    .clk      (clk),
    .rst      (rst),
    .we       (fill_we),
    .waddr    (fill_waddr),
    .wdata    (fill_wdata),
    .fill_done(fill_done)
  );

  stwp_ram #(
    .WIDTH(SINE_BITS),
    .DEPTH(TABLE_POINTS)
  ) u_sine_ram (
    .clk  (clk),
    .we   (fill_we),
    .waddr(fill_waddr),
    .wdata(fill_wdata),
    .re   (table_re),
    .raddr(issue_phase),
    .rdata(table_rdata)
  );

  stwp_sample_path #(
    .TABLE_POINTS(TABLE_POINTS),
    .SINE_BITS   (SINE_BITS)
  ) u_sample_path (
    .clk         (clk),
    .rst         (rst),
    .issue       (issue),
    .issue_phase (issue_phase),
    .issue_ready (issue_ready),
    .table_re    (table_re),
    .table_rdata (table_rdata),
    .magnitude   (magnitude),
    .offset      (offset),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .dac_code    (dac_code),
    .sample_index(sample_index)
  );

endmodule

FILE: rtl/stwp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module stwp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/stwp_table_fill.sv
// Loads the sine table into the sample RAM after reset, one entry per cycle.
// The entries are worked out at elaboration; depends on stwp_pkg.
module stwp_table_fill
  import stwp_pkg::*;
#(
  parameter int TABLE_POINTS = DEFAULT_TABLE_POINTS,
  parameter int SINE_BITS    = DEFAULT_SINE_BITS,
  localparam int PHASE_W = $clog2(TABLE_POINTS)
) (
  input  logic                 clk,
  input  logic                 rst,
  output logic                 we,
  output logic [PHASE_W-1:0]   waddr,
  output logic [SINE_BITS-1:0] wdata,
  output logic                 fill_done
);

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam int SH = 31 - SINE_BITS;

  function automatic logic [SINE_BITS-1:0] sine_entry(input int unsigned p);
    longint unsigned q;
    longint unsigned quad;
    longint unsigned rem;
    longint unsigned m;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned mag;
    longint unsigned lim;
    logic [SINE_BITS-1:0] e;
    q    = 64'd4 * longint'(p);
    quad = q / TABLE_POINTS;
    rem  = q % TABLE_POINTS;
    m    = quad[0] ? (longint'(TABLE_POINTS) - rem) : rem;
    x    = (HALF_PI_Q30 * m) / TABLE_POINTS;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 110;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 156;
    sum  = sum + term;
    mag  = (sum + (64'd1 << (SH - 1))) >> SH;
    lim  = (64'd1 << (SINE_BITS - 1)) - 64'd1;
    if (mag > lim) begin
      mag = lim;
    end
    e = SINE_BITS'(mag);
    if (quad >= 64'd2) begin
      e = -e;
    end
    return e;
  endfunction

  logic [SINE_BITS-1:0] table_init [TABLE_POINTS];

  for (genvar g = 0; g < TABLE_POINTS; g++) begin : g_table
    assign table_init[g] = sine_entry(g);
  end

  logic [PHASE_W-1:0] fill_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_addr <= '0;
      fill_done <= 1'b0;
    end else if (!fill_done) begin
      if (fill_addr == PHASE_W'(TABLE_POINTS - 1)) begin
        fill_done <= 1'b1;
      end else begin
        fill_addr <= fill_addr + 1'b1;
      end
    end
  end

  assign we    = !fill_done;
  assign waddr = fill_addr;
  assign wdata = table_init[fill_addr];

endmodule

FILE: rtl/stwp_sequencer.sv
// Configuration registers, tick counter, table position and parked flag.
// Decides which transactions issue a sample; depends on stwp_pkg.
module stwp_sequencer
  import stwp_pkg::*;
#(
  parameter int TABLE_POINTS = DEFAULT_TABLE_POINTS,
  localparam int PHASE_W = $clog2(TABLE_POINTS)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_fire,
  input  logic                       tick_present,
  input  logic                       cfg_fire,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  output stage_ctl_t                 issue,
  output logic [PHASE_W-1:0]         issue_phase,
  output logic [MAG_W-1:0]           magnitude,
  output logic signed [OFFSET_W-1:0] offset
);

  logic [PERIOD_W-1:0] period;
  logic [PERIOD_W-1:0] tick_count;
  logic [PERIOD_W-1:0] tick_count_next;
  logic [PERIOD_W-1:0] count_inc;
  logic [PHASE_W-1:0]  phase;
  logic [PHASE_W-1:0]  phase_next;
  logic                parked;
  logic                parked_next;
  logic                emit;

  always_comb begin
    count_inc       = tick_count + 1'b1;
    tick_count_next = tick_count;
    phase_next      = phase;
    parked_next     = parked;
    emit            = 1'b0;
    issue.park      = 1'b0;
    if (period == '0) begin
      tick_count_next = '0;
      phase_next      = '0;
      parked_next     = 1'b1;
      emit            = !parked;
      issue.park      = 1'b1;
    end else begin
      parked_next = 1'b0;
      if (tick_present) begin
        if (count_inc >= period) begin
          tick_count_next = '0;
          emit            = 1'b1;
          if (phase == PHASE_W'(TABLE_POINTS - 1)) begin
            phase_next = '0;
          end else begin
            phase_next = phase + 1'b1;
          end
        end else begin
          tick_count_next = count_inc;
        end
      end
    end
    issue.valid = in_fire && emit;
  end

  assign issue_phase = phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      period     <= '0;
      magnitude  <= '0;
      offset     <= '0;
      tick_count <= '0;
      phase      <= '0;
      parked     <= 1'b0;
    end else begin
      if (cfg_fire && cfg_index == REG_PERIOD) begin
        tick_count <= '0;
        phase      <= '0;
        parked     <= 1'b0;
      end else if (in_fire) begin
        tick_count <= tick_count_next;
        phase      <= phase_next;
        parked     <= parked_next;
      end
      if (cfg_fire) begin
        unique case (cfg_reg_e'(cfg_index))
          REG_PERIOD: begin
            period <= cfg_data[PERIOD_W-1:0];
          end
          REG_MAGNITUDE: begin
            magnitude <= cfg_data[MAG_W-1:0];
          end
          REG_OFFSET: begin
            offset <= cfg_data[OFFSET_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

FILE: rtl/stwp_sample_path.sv
// Sample pipeline: table read, amplitude multiply, offset add and saturation.
// Holds the output register; depends on stwp_pkg.
module stwp_sample_path
  import stwp_pkg::*;
#(
  parameter int TABLE_POINTS = DEFAULT_TABLE_POINTS,
  parameter int SINE_BITS    = DEFAULT_SINE_BITS,
  localparam int PHASE_W = $clog2(TABLE_POINTS)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  stage_ctl_t                 issue,
  input  logic [PHASE_W-1:0]         issue_phase,
  output logic                       issue_ready,
  output logic                       table_re,
  input  logic [SINE_BITS-1:0]       table_rdata,
  input  logic [MAG_W-1:0]           magnitude,
  input  logic signed [OFFSET_W-1:0] offset,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [CODE_W-1:0]          dac_code,
  output logic [INDEX_W-1:0]         sample_index
);

  localparam int PROD_W = MAG_W + 1 + SINE_BITS;
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(CODE_MAX);

  stage_ctl_t                 s1;
  logic [PHASE_W-1:0]         s1_phase;
  stage_ctl_t                 s2;
  logic [PHASE_W-1:0]         s2_phase;
  logic signed [PROD_W-1:0]   s2_product;
  logic                       out_load;
  logic                       s2_ready;
  logic signed [SUM_W-1:0]    scaled;
  logic signed [SUM_W-1:0]    sum;
  logic [CODE_W-1:0]          code;

  assign out_load    = !out_valid || out_ready;
  assign s2_ready    = !s2.valid || out_load;
  assign issue_ready = !s1.valid || s2_ready;
  assign table_re    = issue_ready;

  always_comb begin
    scaled = SUM_W'(s2_product >>> (SINE_BITS - 1));
    sum    = SUM_W'(MIDSCALE) + SUM_W'(offset) + scaled;
    if (s2.park) begin
      code = CODE_W'(MIDSCALE);
    end else if (sum < 0) begin
      code = '0;
    end else if (sum > SUM_MAX) begin
      code = CODE_W'(CODE_MAX);
    end else begin
      code = sum[CODE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1        <= '0;
      s2        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (issue_ready) begin
        s1 <= issue;
      end
      if (s2_ready) begin
        s2 <= s1;
      end
      if (out_load) begin
        out_valid <= s2.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue_ready) begin
      s1_phase <= issue_phase;
    end
    if (s2_ready) begin
      s2_phase   <= s1_phase;
      s2_product <= $signed({1'b0, magnitude}) * $signed(table_rdata);
    end
    if (out_load) begin
      dac_code     <= code;
      sample_index <= INDEX_W'(s2_phase);
    end
  end

endmodule

FILE: rtl/stwp_checker.sv
// Port-level checker for the sine table waveform player, bound to the top level.
// Depends on stwp_pkg and sine_table_waveform_player_unit.
module stwp_checker
  import stwp_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [CODE_W-1:0]  dac_code,
  input logic [INDEX_W-1:0] sample_index
);

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(dac_code) && $stable(sample_index))
    else $error("Stalled output transaction changed or was dropped.");

  assert property (@(posedge clk) rst |=> !in_ready && !out_valid)
    else $error("Channels not quiet after reset.");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 3))
    else $error("Output transaction without an input transaction three cycles earlier.");

endmodule

bind sine_table_waveform_player_unit stwp_checker u_checker (.*);

FILE: bench/tb_top.sv
// Self-checking testbench for sine_table_waveform_player_unit.
// Predicts each DAC sample from an integer sine table model and compares every
// output transaction; depends only on stwp_pkg and the unit itself.
module tb_top;
  import stwp_pkg::*;

  localparam int POINTS      = DEFAULT_TABLE_POINTS;
  localparam int SBITS       = DEFAULT_SINE_BITS;
  localparam int CYCLE_CAP   = 300000;
  localparam int SETTLE      = 8;
  localparam int RAND_ITEMS  = 950;
  localparam int TAIL_ITEMS  = 120;
  localparam int PAUSE_ITEMS = 40;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  typedef struct {
    logic [CODE_W-1:0]  code;
    logic [INDEX_W-1:0] pos;
  } sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic tick_present = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CODE_W-1:0] dac_code;
  logic [INDEX_W-1:0] sample_index;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sine_table_waveform_player_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .tick_present(tick_present),
    .out_valid(out_valid), .out_ready(out_ready),
    .dac_code(dac_code), .sample_index(sample_index),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int sine_tab [POINTS];
  logic [PERIOD_W-1:0] period_r = '0;
  logic [MAG_W-1:0] mag_r = '0;
  logic signed [OFFSET_W-1:0] offs_r = '0;
  logic [PERIOD_W-1:0] count_r = '0;
  logic [INDEX_W-1:0] pos_r = '0;
  bit parked_r = 1'b0;

  sample_t pending_samples[$];
  sample_t want;
  int errors = 0;
  int items_sent = 0;
  int samples_seen = 0;
  int reg_writes = 0;
  int cycles = 0;
  bit idling_on = 1'b1;
  int stall_left = 0;

  function automatic longint unsigned quarter_wave_q30(int unsigned m);
    longint unsigned x, x2, term, acc;
    int k;
    x = (64'd1686629713 * m) / POINTS;
    x2 = (x * x) >> 30;
    term = x;
    acc = x;
    for (k = 1; k <= 6; k++) begin
      term = ((term * x2) >> 30) / (2 * k * (2 * k + 1));
      if (k % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    return acc;
  endfunction

  function automatic int sine_value(int unsigned p);
    int unsigned q, quad, rem, m;
    longint unsigned mag;
    q = 4 * (p % POINTS);
    quad = q / POINTS;
    rem = q % POINTS;
    m = (quad % 2 == 1) ? POINTS - rem : rem;
    mag = (quarter_wave_q30(m) + (64'd1 << (30 - SBITS))) >> (31 - SBITS);
    if (mag > (64'd1 << (SBITS - 1)) - 1) mag = (64'd1 << (SBITS - 1)) - 1;
    return (quad >= 2) ? -int'(mag) : int'(mag);
  endfunction

  function automatic logic [CODE_W-1:0] dac_value(logic [INDEX_W-1:0] p);
    longint prod, scaled, v;
    prod = longint'(mag_r) * longint'(sine_tab[p]);
    if (prod >= 0) scaled = prod >>> (SBITS - 1);
    else scaled = -((-prod + (64'sd1 <<< (SBITS - 1)) - 1) >>> (SBITS - 1));
    v = longint'(MIDSCALE) + longint'(offs_r) + scaled;
    if (v < 0) v = 0;
    if (v > CODE_MAX) v = CODE_MAX;
    return v[CODE_W-1:0];
  endfunction

  task automatic player_step(input bit t);
    if (period_r == 0) begin
      count_r = '0;
      pos_r = '0;
      if (!parked_r) begin
        parked_r = 1'b1;
        pending_samples.push_back('{code: CODE_W'(MIDSCALE), pos: '0});
      end
    end else begin
      parked_r = 1'b0;
      if (t) begin
        count_r = count_r + 1'b1;
        if (count_r >= period_r) begin
          count_r = '0;
          pending_samples.push_back('{code: dac_value(pos_r), pos: pos_r});
          pos_r = pos_r + 1'b1;
        end
      end
    end
  endtask

  task automatic send_tick(input bit t);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    tick_present <= t;
    do @(posedge clk); while (!in_ready);
    player_step(t);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PERIOD: begin
        period_r = val;
        count_r = '0;
        pos_r = '0;
        parked_r = 1'b0;
      end
      REG_MAGNITUDE: mag_r = val[MAG_W-1:0];
      REG_OFFSET: offs_r = val[OFFSET_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
  endtask

  task automatic let_drain();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] noisy(int width, logic [CFG_DATA_W-1:0] val);
    logic [CFG_DATA_W-1:0] mask;
    mask = (24'd1 << width) - 24'd1;
    return (val & mask) | (CFG_DATA_W'($urandom()) & ~mask);
  endfunction

  task automatic test_park_after_reset();
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    let_drain();
  endtask

  task automatic test_saturation();
    int i;
    write_reg(REG_MAGNITUDE, noisy(MAG_W, 24'hFFFF));
    write_reg(REG_OFFSET, noisy(OFFSET_W, 24'h0FFFF));
    write_reg(REG_PERIOD, 24'd1);
    end_writes();
    for (i = 0; i < 4; i++) send_tick(1'b1);
    let_drain();
    write_reg(REG_OFFSET, noisy(OFFSET_W, 24'h10000));
    end_writes();
    for (i = 0; i < 4; i++) send_tick(i != 1);
    let_drain();
    write_reg(REG_MAGNITUDE, noisy(MAG_W, 24'h0000));
    write_reg(REG_OFFSET, noisy(OFFSET_W, 24'h10001));
    end_writes();
    send_tick(1'b1);
    send_tick(1'b1);
    let_drain();
  endtask

  task automatic test_long_period_and_stop();
    write_reg(REG_OFFSET, 24'h0);
    write_reg(REG_MAGNITUDE, 24'h8000);
    write_reg(REG_PERIOD, 24'hFFFFFF);
    end_writes();
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    let_drain();
    write_reg(REG_PERIOD, 24'h0);
    end_writes();
    send_tick(1'b1);
    send_tick(1'b0);
    let_drain();
  endtask

  task automatic test_spare_register();
    write_reg(REG_PERIOD, 24'd2);
    write_reg(REG_SPARE, CFG_DATA_W'($urandom()));
    end_writes();
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
    let_drain();
  endtask

  task automatic random_phase(input int n);
    int i, sel;
    logic [CFG_DATA_W-1:0] val;
    sel = $urandom_range(0, 3);
    val = (sel == 0) ? 24'h0000 : (sel == 1) ? 24'hFFFF : CFG_DATA_W'($urandom());
    write_reg(REG_MAGNITUDE, noisy(MAG_W, val));
    sel = $urandom_range(0, 5);
    val = (sel == 0) ? 24'h0FFFF : (sel == 1) ? 24'h10000 : (sel == 2) ? 24'h10001 :
          (sel == 3) ? 24'h0 : CFG_DATA_W'($urandom());
    write_reg(REG_OFFSET, noisy(OFFSET_W, val));
    if ($urandom_range(0, 1) == 0) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) val = 24'h0;
      else if (sel <= 3) val = 24'd1;
      else if (sel <= 7) val = CFG_DATA_W'($urandom_range(2, 6));
      else if (sel == 8) val = CFG_DATA_W'($urandom_range(7, 300));
      else val = CFG_DATA_W'($urandom());
      write_reg(REG_PERIOD, val);
    end
    if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE, CFG_DATA_W'($urandom()));
    end_writes();
    for (i = 0; i < n; i++) send_tick($urandom_range(0, 3) != 0);
    let_drain();
  endtask

  task automatic test_random_streams();
    int n;
    while (items_sent < RAND_ITEMS - TAIL_ITEMS - 3 * PAUSE_ITEMS) begin
      idling_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(20, 150);
      random_phase(n / 2);
      if (n % 5 == 0) begin
        for (int i = 0; i < n / 2; i++) send_tick($urandom_range(0, 3) != 0);
        let_drain();
      end
    end
  endtask

  task automatic test_drain_pause();
    int i;
    idling_on = 1'b1;
    write_reg(REG_PERIOD, 24'd1);
    end_writes();
    for (i = 0; i < PAUSE_ITEMS; i++) send_tick(1'b1);
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    for (i = 0; i < PAUSE_ITEMS; i++) send_tick($urandom_range(0, 1) != 0);
    let_drain();
  endtask

  task automatic test_quiet_tail();
    idling_on = 1'b0;
    random_phase(TAIL_ITEMS);
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        errors++;
        $display("%0t: unexpected sample, expected none, actual dac_code %0d sample_index %0d",
                 $time, dac_code, sample_index);
      end else begin
        want = pending_samples.pop_front();
        samples_seen++;
        if (dac_code !== want.code) begin
          errors++;
          $display("%0t: dac_code expected %0d actual %0d", $time, want.code, dac_code);
        end
        if (sample_index !== want.pos) begin
          errors++;
          $display("%0t: sample_index expected %0d actual %0d", $time, want.pos,
                   sample_index);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("sine_table_waveform_player_unit: mismatch");
      $finish;
    end
  end

  initial begin
    for (int p = 0; p < POINTS; p++) sine_tab[p] = sine_value(p);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_park_after_reset();
    test_saturation();
    test_long_period_and_stop();
    test_spare_register();
    test_random_streams();
    test_drain_pause();
    test_quiet_tail();
    $display("Sent %0d tick transactions and checked %0d samples after %0d register writes.",
             items_sent, samples_seen, reg_writes);
    $display("Covered parking, saturation, long and short periods and output back-pressure.");
    if (errors == 0) begin
      $display("sine_table_waveform_player_unit: match");
    end else begin
      $display("sine_table_waveform_player_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/stwp_pkg.sv
rtl/stwp_ram.sv
rtl/stwp_table_fill.sv
rtl/stwp_sequencer.sv
rtl/stwp_sample_path.sv
rtl/sine_table_waveform_player_unit.sv
rtl/stwp_checker.sv
bench/tb_top.sv
